// ===== rtl/ahffr_pkg.sv =====
package ahffr_pkg;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_SIZE,
    PH_CSUM,
    PH_DATA
  } phase_t;

  typedef enum logic [2:0] {
    K_SYNC     = 3'd0,
    K_DATA     = 3'd1,
    K_OK       = 3'd2,
    K_EMPTY    = 3'd3,
    K_CSUM_BAD = 3'd4,
    K_NUM_BAD  = 3'd5,
    K_HEX_BAD  = 3'd6
  } kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_dig;
    logic       is_hex;
    logic       is_lf;
    logic [3:0] hval;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam int TEXT_LEN = 12;
  localparam logic [8*TEXT_LEN-1:0] SYNC_TEXT = "serial sync\n";
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [35:0] VALUE_MAX = 36'h07FFFFFFF;
  localparam logic [31:0] VALUE_OVER = 32'h80000000;

  localparam int QDEPTH = 2;
  localparam int QAW = $clog2(QDEPTH);

endpackage

// ===== rtl/ahffr_front.sv =====
module ahffr_front (
  input  logic              in_valid,
  input  logic [7:0]        in_rx_byte,
  output logic              in_stall,
  input  ahffr_pkg::q_stat_t q_stat,
  output logic              push,
  output ahffr_pkg::item_t  item
);
  import ahffr_pkg::*;

  function automatic item_t classify(input logic [7:0] c);
    item_t r;
    r.ch     = c;
    r.is_dig = 1'b0;
    r.is_hex = 1'b0;
    r.is_lf  = (c == CHAR_LF);
    r.hval   = 4'd0;
    if (c >= "0" && c <= "9") begin
      r.is_dig = 1'b1;
      r.is_hex = 1'b1;
      r.hval   = 4'(c - 8'h30);
    end else if (c >= "a" && c <= "f") begin
      r.is_hex = 1'b1;
      r.hval   = 4'(c - 8'h57);
    end else if (c >= "A" && c <= "F") begin
      r.is_hex = 1'b1;
      r.hval   = 4'(c - 8'h37);
    end
    return r;
  endfunction

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;
  assign item     = classify(in_rx_byte);

endmodule

// ===== rtl/ahffr_queue.sv =====
module ahffr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ahffr_pkg::item_t   wr_item,
  input  logic               pop,
  output ahffr_pkg::item_t   rd_item,
  output ahffr_pkg::q_stat_t q_stat
);
  import ahffr_pkg::*;

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wptr_r, wptr_nxt;
  logic [QAW-1:0] rptr_r, rptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign q_stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;
  assign rd_item = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == QAW'(QDEPTH-1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QAW'(QDEPTH-1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wr_item;
    end
  end

endmodule

// ===== rtl/ahffr_back.sv =====
module ahffr_back #(
  parameter int SYNC_LEN   = 12,
  parameter int MAX_DIGITS = 30,
  parameter int NUM_FILES  = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ahffr_pkg::item_t item,
  input  logic             q_empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_data_byte,
  output logic             out_is_last_byte,
  output logic             out_payload_index,
  output logic [15:0]      out_computed_sum
);
  import ahffr_pkg::*;

  localparam int M  = (SYNC_LEN < TEXT_LEN) ? SYNC_LEN : TEXT_LEN;
  localparam int PW = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
  localparam int DW = $clog2(MAX_DIGITS + 1);

  phase_t              phase_r, phase_nxt;
  logic [8*SYNC_LEN-1:0] win_r, win_nxt, win_shift;
  logic [DW-1:0]       dcnt_r, dcnt_nxt, dcnt_inc;
  logic [31:0]         acc_r, acc_nxt, acc_digit;
  logic [35:0]         acc_mul;
  logic [30:0]         left_r, left_nxt, left_dec;
  logic [15:0]         exp_r, exp_nxt;
  logic [15:0]         sum_r, sum_nxt, sum_add;
  logic [1:0]          pos_r, pos_nxt;
  logic [3:0]          hi_r, hi_nxt;
  logic [PW-1:0]       cur_r, cur_nxt;
  logic                out_valid_r, out_valid_nxt;
  kind_t               kind_r, kind_nxt;
  logic [7:0]          data_r, data_nxt;
  logic                last_r, last_nxt;
  logic                idx_r, idx_nxt;
  logic [15:0]         osum_r, osum_nxt;
  logic                fire, hit, last_file, emit, do_hunt, do_start;

  generate
    if (SYNC_LEN > 1) begin : g_shift
      assign win_shift = {win_r[8*SYNC_LEN-9:0], item.ch};
    end else begin : g_single
      assign win_shift = item.ch;
    end
  endgenerate

  always_comb begin
    hit = 1'b1;
    for (int k = 0; k < M; k++) begin
      if (win_shift[8*k +: 8] != SYNC_TEXT[8*k +: 8]) begin
        hit = 1'b0;
      end
    end
  end

  assign fire      = !q_empty && (!out_valid_r || !out_stall);
  assign pop       = fire;
  assign dcnt_inc  = dcnt_r + 1'b1;
  assign acc_mul   = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {32'd0, item.hval};
  assign acc_digit = (acc_mul > VALUE_MAX) ? VALUE_OVER : acc_mul[31:0];
  assign left_dec  = left_r - 1'b1;
  assign sum_add   = sum_r + {8'd0, hi_r, item.hval};
  assign last_file = ({1'b0, cur_r} + 1'b1) >= (PW+1)'(NUM_FILES);

  always_comb begin
    phase_nxt     = phase_r;
    win_nxt       = win_r;
    dcnt_nxt      = dcnt_r;
    acc_nxt       = acc_r;
    left_nxt      = left_r;
    exp_nxt       = exp_r;
    sum_nxt       = sum_r;
    pos_nxt       = pos_r;
    hi_nxt        = hi_r;
    cur_nxt       = cur_r;
    kind_nxt      = kind_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    osum_nxt      = osum_r;
    out_valid_nxt = out_valid_r && out_stall;
    emit          = 1'b0;
    do_hunt       = 1'b0;
    do_start      = 1'b0;
    kind_nxt      = kind_r;

    if (fire) begin
      data_nxt = 8'd0;
      last_nxt = 1'b0;
      idx_nxt  = cur_r[0];
      osum_nxt = sum_r;
      case (phase_r)
        PH_HUNT: begin
          win_nxt = win_shift;
          if (hit) begin
            emit     = 1'b1;
            kind_nxt = K_SYNC;
            idx_nxt  = 1'b0;
            osum_nxt = 16'd0;
            win_nxt  = '0;
            cur_nxt  = '0;
            do_start = 1'b1;
          end
        end
        PH_SIZE, PH_CSUM: begin
          if (item.is_dig) begin
            dcnt_nxt = dcnt_inc;
            if (dcnt_inc >= DW'(MAX_DIGITS)) begin
              emit     = 1'b1;
              kind_nxt = K_NUM_BAD;
              do_hunt  = 1'b1;
            end else begin
              acc_nxt = acc_digit;
            end
          end else if (acc_r[31]) begin
            emit     = 1'b1;
            kind_nxt = K_NUM_BAD;
            do_hunt  = 1'b1;
          end else if (phase_r == PH_SIZE) begin
            left_nxt = acc_r[30:0];
            dcnt_nxt = '0;
            acc_nxt  = '0;
            if (acc_r[30:0] == '0) begin
              emit     = 1'b1;
              kind_nxt = K_EMPTY;
              if (last_file) begin
                do_hunt = 1'b1;
              end else begin
                cur_nxt  = cur_r + 1'b1;
                do_start = 1'b1;
              end
            end else begin
              phase_nxt = PH_CSUM;
            end
          end else begin
            exp_nxt   = acc_r[15:0];
            dcnt_nxt  = '0;
            acc_nxt   = '0;
            pos_nxt   = 2'd0;
            hi_nxt    = 4'd0;
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          if (pos_r < 2'd2) begin
            if (!item.is_hex) begin
              emit     = 1'b1;
              kind_nxt = K_HEX_BAD;
              do_hunt  = 1'b1;
            end else if (pos_r == 2'd0) begin
              pos_nxt = 2'd1;
              hi_nxt  = item.hval;
            end else begin
              sum_nxt  = sum_add;
              left_nxt = left_dec;
              pos_nxt  = 2'd2;
              hi_nxt   = 4'd0;
              emit     = 1'b1;
              kind_nxt = K_DATA;
              data_nxt = {hi_r, item.hval};
              last_nxt = (left_dec == '0);
              osum_nxt = sum_add;
            end
          end else if (!item.is_lf) begin
            emit     = 1'b1;
            kind_nxt = K_HEX_BAD;
            do_hunt  = 1'b1;
          end else begin
            pos_nxt = 2'd0;
            hi_nxt  = 4'd0;
            if (left_r == '0) begin
              emit = 1'b1;
              if (sum_r != exp_r) begin
                kind_nxt = K_CSUM_BAD;
                do_hunt  = 1'b1;
              end else begin
                kind_nxt = K_OK;
                if (last_file) begin
                  do_hunt = 1'b1;
                end else begin
                  cur_nxt  = cur_r + 1'b1;
                  do_start = 1'b1;
                end
              end
            end
          end
        end
        default: begin
          do_hunt = 1'b1;
        end
      endcase

      if (do_hunt) begin
        phase_nxt = PH_HUNT;
        win_nxt   = '0;
        dcnt_nxt  = '0;
        acc_nxt   = '0;
        pos_nxt   = 2'd0;
        hi_nxt    = 4'd0;
      end
      if (do_start) begin
        phase_nxt = PH_SIZE;
        dcnt_nxt  = '0;
        acc_nxt   = '0;
        sum_nxt   = 16'd0;
        pos_nxt   = 2'd0;
        hi_nxt    = 4'd0;
      end
      out_valid_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      win_r       <= '0;
      dcnt_r      <= '0;
      acc_r       <= '0;
      left_r      <= '0;
      exp_r       <= '0;
      sum_r       <= '0;
      pos_r       <= '0;
      hi_r        <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      win_r       <= win_nxt;
      dcnt_r      <= dcnt_nxt;
      acc_r       <= acc_nxt;
      left_r      <= left_nxt;
      exp_r       <= exp_nxt;
      sum_r       <= sum_nxt;
      pos_r       <= pos_nxt;
      hi_r        <= hi_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    data_r <= data_nxt;
    last_r <= last_nxt;
    idx_r  <= idx_nxt;
    osum_r <= osum_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_data_byte     = data_r;
  assign out_is_last_byte  = last_r;
  assign out_payload_index = idx_r;
  assign out_computed_sum  = osum_r;

endmodule

// ===== rtl/ascii_hex_file_frame_receiver.sv =====
// Serial file-frame receiver. Takes one received character per cycle unless
// in_stall is high, hunts for "serial sync\n", then parses NUM_FILES payloads
// (decimal size, decimal checksum, lines of two hex digits and LF) and reports
// sync, each decoded byte, and a verdict per payload. Sustained rate is one
// character per cycle while out_stall stays low; a result is registered: the
// character waits in the two-entry classifier queue and the parser loads the
// output register from it. The rate is set by the parser's per-character state
// update. Reset needs no clearing pass; the sync window is cleared by reset.
module ascii_hex_file_frame_receiver #(
  parameter int SYNC_LEN   = 12,
  parameter int MAX_DIGITS = 30,
  parameter int NUM_FILES  = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic        out_is_last_byte,
  output logic        out_payload_index,
  output logic [15:0] out_computed_sum
);
  import ahffr_pkg::*;

  q_stat_t q_stat;
  item_t   wr_item, rd_item;
  logic    push, pop;

  ahffr_front u_front (
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .q_stat     (q_stat),
    .push       (push),
    .item       (wr_item)
  );

  ahffr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .q_stat  (q_stat)
  );

  ahffr_back #(
    .SYNC_LEN   (SYNC_LEN),
    .MAX_DIGITS (MAX_DIGITS),
    .NUM_FILES  (NUM_FILES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .item              (rd_item),
    .q_empty           (q_stat.empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_is_last_byte  (out_is_last_byte),
    .out_payload_index (out_payload_index),
    .out_computed_sum  (out_computed_sum)
  );

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

  a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_last_byte |-> out_kind == K_DATA)
    else $error("last mark on non-data result");

  a_sync_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_SYNC |-> out_computed_sum == 16'd0 && !out_payload_index)
    else $error("sync result carries payload fields");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ahffr_pkg::*;

  localparam int MAX_DIGITS = 30;
  localparam int NUM_FILES = 2;
  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_SHOWN = 30;
  localparam string SYNC_STR = "serial sync\n";
  localparam logic [7:0] CH_ZERO = "0";
  localparam logic [7:0] CH_NINE = "9";

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
    logic       index;
    logic [15:0] sum;
  } report_t;

  class frame_scoreboard;
    phase_t                  phase;
    logic [8*TEXT_LEN-1:0]   window;
    int unsigned             digits;
    logic [31:0]             accum;
    logic [30:0]             left;
    logic [15:0]             csum;
    logic [15:0]             sum;
    logic [1:0]              pos;
    logic [3:0]              hi;
    int unsigned             payload;
    report_t                 due_reports[$];
    int                      fails;

    function new();
      go_hunt();
      left = '0;
      csum = '0;
      sum = '0;
      payload = 0;
      fails = 0;
    endfunction

    function void go_hunt();
      phase = PH_HUNT;
      window = '0;
      digits = 0;
      accum = '0;
      pos = '0;
      hi = '0;
    endfunction

    function void start_payload();
      phase = PH_SIZE;
      digits = 0;
      accum = '0;
      sum = '0;
      pos = '0;
      hi = '0;
    endfunction

    function void next_payload();
      if (payload + 1 >= NUM_FILES) begin
        go_hunt();
      end else begin
        payload++;
        start_payload();
      end
    endfunction

    function void add_report(kind_t k, logic [7:0] d, logic last);
      report_t r;
      r.kind = k;
      r.data = d;
      r.last = last;
      r.index = (k == K_SYNC) ? 1'b0 : payload[0];
      r.sum = (k == K_SYNC) ? 16'd0 : sum;
      due_reports.push_back(r);
    endfunction

    function int pending();
      return due_reports.size();
    endfunction

    function void take_char(logic [7:0] c);
      logic [63:0] grown;
      logic [7:0] b;
      int h;
      if (phase == PH_HUNT) begin
        window = {window[8*TEXT_LEN-9:0], c};
        if (window == SYNC_TEXT) begin
          go_hunt();
          payload = 0;
          start_payload();
          add_report(K_SYNC, 8'd0, 1'b0);
        end
        return;
      end
      if (phase == PH_SIZE || phase == PH_CSUM) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          digits++;
          if (digits >= MAX_DIGITS) begin
            add_report(K_NUM_BAD, 8'd0, 1'b0);
            go_hunt();
          end else begin
            grown = 64'(accum) * 64'd10 + 64'(c - CH_ZERO);
            if (grown > VALUE_MAX) grown = 64'(VALUE_OVER);
            accum = grown[31:0];
          end
          return;
        end
        if (accum > VALUE_MAX) begin
          add_report(K_NUM_BAD, 8'd0, 1'b0);
          go_hunt();
          return;
        end
        if (phase == PH_SIZE) begin
          left = accum[30:0];
          digits = 0;
          accum = '0;
          if (left == 0) begin
            add_report(K_EMPTY, 8'd0, 1'b0);
            next_payload();
          end else begin
            phase = PH_CSUM;
          end
        end else begin
          csum = accum[15:0];
          digits = 0;
          accum = '0;
          pos = '0;
          hi = '0;
          phase = PH_DATA;
        end
        return;
      end
      // hex lines
      if (pos < 2) begin
        h = -1;
        if (c >= CH_ZERO && c <= CH_NINE) h = int'(c - CH_ZERO);
        else if (c >= "a" && c <= "f") h = int'(c - "a") + 10;
        else if (c >= "A" && c <= "F") h = int'(c - "A") + 10;
        if (h < 0) begin
          add_report(K_HEX_BAD, 8'd0, 1'b0);
          go_hunt();
          return;
        end
        if (pos == 0) begin
          pos = 2'd1;
          hi = 4'(h);
          return;
        end
        b = {hi, 4'(h)};
        sum = sum + 16'(b);
        left = left - 31'd1;
        pos = 2'd2;
        hi = '0;
        add_report(K_DATA, b, left == 0);
        return;
      end
      if (c != CHAR_LF) begin
        add_report(K_HEX_BAD, 8'd0, 1'b0);
        go_hunt();
        return;
      end
      pos = '0;
      if (left != 0) return;
      if (sum != csum) begin
        add_report(K_CSUM_BAD, 8'd0, 1'b0);
        go_hunt();
      end else begin
        add_report(K_OK, 8'd0, 1'b0);
        next_payload();
      end
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        fails++;
        if (fails <= MAX_SHOWN)
          $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_report(logic [2:0] k, logic [7:0] d, logic last, logic index,
                               logic [15:0] s);
      report_t want;
      if (due_reports.size() == 0) begin
        fails++;
        if (fails <= MAX_SHOWN)
          $display("%0t: report with none due, kind expected none, actual %0d", $time, k);
        return;
      end
      want = due_reports.pop_front();
      check_field("kind", want.kind, k);
      check_field("data_byte", want.data, d);
      check_field("is_last_byte", want.last, last);
      check_field("payload_index", want.index, index);
      check_field("computed_sum", want.sum, s);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic        out_is_last_byte;
  logic        out_payload_index;
  logic [15:0] out_computed_sum;

  frame_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  int sent_count = 0;
  int quiet_cycles = 0;

  ascii_hex_file_frame_receiver u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_data_byte(out_data_byte),
    .out_is_last_byte(out_is_last_byte),
    .out_payload_index(out_payload_index),
    .out_computed_sum(out_computed_sum)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.take_char(in_rx_byte);
    if (rst_n && out_valid && !out_stall)
      sb.check_report(out_kind, out_data_byte, out_is_last_byte, out_payload_index,
                      out_computed_sum);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("ascii_hex_file_frame_receiver verification failed");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= c;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_number(input longint unsigned v, input int zeros);
    string s;
    s = $sformatf("%0d", v);
    repeat (zeros) s = {"0", s};
    send_text(s);
  endtask

  task automatic wait_for_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_ZERO + 8'(n);
    return (($urandom_range(1) == 1) ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] rand_terminator();
    logic [7:0] c;
    case ($urandom_range(3))
      0: c = CHAR_LF;
      1: c = " ";
      2: c = 8'($urandom_range(128, 255));
      default: begin
        c = 8'($urandom_range(255));
        while (c >= CH_ZERO && c <= CH_NINE) c = 8'($urandom_range(255));
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] bad_char(input bit at_lf);
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (at_lf ? (c == CHAR_LF) :
           ((c >= CH_ZERO && c <= CH_NINE) || (c >= "a" && c <= "f") ||
            (c >= "A" && c <= "F")))
      c = 8'($urandom_range(255));
    return c;
  endfunction

  // one session: hunt noise, sync, then payloads with random faults
  task automatic send_random_frame(input int big);
    int mode;
    int n;
    int bad_line;
    int bad_pos;
    int i;
    logic [15:0] total;
    longint unsigned csum_val;
    logic [7:0] bytes_q[$];
    repeat ($urandom_range(0, 4)) send_char(8'($urandom_range(255)));
    if ($urandom_range(3) == 0) send_text("serial s");
    send_text(SYNC_STR);
    for (int p = 0; p < NUM_FILES; p++) begin
      mode = (big != 0) ? 99 : $urandom_range(99);
      if (mode < 12) begin
        if ($urandom_range(1) == 1) send_number(0, $urandom_range(0, 3));
        send_char(rand_terminator());
        continue;
      end
      if (mode < 20) begin
        if ($urandom_range(1) == 1) begin
          send_number($urandom_range(1, 4), 0);
          send_char(rand_terminator());
        end
        if ($urandom_range(1) == 1) begin
          repeat (MAX_DIGITS) send_char(CH_ZERO + 8'($urandom_range(9)));
        end else begin
          send_number(64'h80000000 + 64'($urandom) * $urandom_range(1, 1000), 0);
          send_char(rand_terminator());
        end
        return;
      end
      n = (big != 0) ? big :
          (($urandom_range(9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4));
      bytes_q.delete();
      total = '0;
      repeat (n) begin
        bytes_q.push_back((big != 0) ? 8'($urandom_range(240, 255)) : 8'($urandom));
        total = total + 16'(bytes_q[$]);
      end
      csum_val = total;
      if (mode < 32) csum_val = csum_val + $urandom_range(1, 65535);
      else if ($urandom_range(3) == 0) csum_val = csum_val + 64'd65536 * $urandom_range(1, 30000);
      send_number(n, ($urandom_range(3) == 0) ? 1 : 0);
      send_char(rand_terminator());
      if (csum_val != 0 || $urandom_range(1) == 0) send_number(csum_val, $urandom_range(0, 1));
      send_char(rand_terminator());
      bad_line = (mode >= 32 && mode < 44) ? $urandom_range(0, n - 1) : -1;
      bad_pos = $urandom_range(2);
      for (i = 0; i < n; i++) begin
        if (i == bad_line) begin
          if (bad_pos > 0) send_char(hex_char(bytes_q[i][7:4]));
          if (bad_pos > 1) send_char(hex_char(bytes_q[i][3:0]));
          send_char(bad_char(bad_pos == 2));
          return;
        end
        send_char(hex_char(bytes_q[i][7:4]));
        send_char(hex_char(bytes_q[i][3:0]));
        send_char(CHAR_LF);
      end
      if (mode < 32) return;
    end
  endtask

  initial begin
    int target;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty then single byte payload
    send_text("serial sync\n0\n1\n255\nfF\n");
    // broken sync, empty size and empty checksum
    send_text("serial sync");
    send_char(8'hC5);
    send_text("serial sync\n,2 x00\n00\n");
    // size just past the value limit
    send_text("serial sync\n2147483648 ");
    // digit limit
    send_text(SYNC_STR);
    repeat (MAX_DIGITS) send_char("9");
    // longest legal number, checksum above 16 bits
    send_text("serial sync\n0 ");
    send_number(1, 28);
    send_text("\n65537\n01\n");
    // checksum mismatch
    send_text("serial sync\n1\n2147483647\nAb\n");
    // bad hex digit, bad line end, high character
    send_text("serial sync\n1\n0\ng");
    send_text("serial sync\n2\n0\n12x");
    send_text("serial sync\n1\n0\n0");
    send_char(8'hE0);
    wait_for_reports();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 55; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 55; end
        default: begin send_idle = 14; recv_stall = 14; end
      endcase
      target = sent_count + 40;
      while (sent_count < target) send_random_frame(0);
      if (ph == 0) send_random_frame(6);
      wait_for_reports();
    end

    repeat (8) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("ascii_hex_file_frame_receiver verification clean");
    end else begin
      $display("ascii_hex_file_frame_receiver verification failed");
    end
    $finish;
  end

endmodule
